>>> hw/rtl/clipped_alpha_blend_pixel_store_assert.svh
// Assertion macros for the clipped alpha-blend pixel store.
// Plain text only; taken in by the top level with `include.
`ifndef CLIPPED_ALPHA_BLEND_PIXEL_STORE_ASSERT_SVH
`define CLIPPED_ALPHA_BLEND_PIXEL_STORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CABPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cabps assertion failed");

// Next-cycle implication, disabled during reset
`define CABPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cabps assertion failed");

`endif

>>> hw/rtl/cabps_pkg.sv
// Shared types, constants and the divide-by-255 helper for the pixel store.
// No dependencies; the RTL modules refer to it by scoped names.
package cabps_pkg;

  // Default frame geometry
  localparam int FRAME_WIDTH_DEF  = 256;
  localparam int FRAME_HEIGHT_DEF = 256;

  // Register widths and reset values
  localparam int CLIP_W  = 9;
  localparam int COLOR_W = 32;
  localparam int COORD_W = 12;
  localparam logic [CLIP_W-1:0]  CLIP_COLS_RST   = 9'd256;
  localparam logic [CLIP_W-1:0]  CLIP_HEIGHT_RST = 9'd256;
  localparam logic [COLOR_W-1:0] FALLBACK_RST    = 32'hFF00_0000;

  // Operation codes carried on in_tuser
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CLIP_COLS   = 2'd0,
    CFG_CLIP_HEIGHT = 2'd1,
    CFG_FALLBACK    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic               we;
    logic [1:0]         index;
    logic [COLOR_W-1:0] data;
  } cfg_wr_t;

  // Classified item handed from front to back (address travels beside it)
  typedef struct packed {
    logic       func;
    logic       inr;
    logic [7:0] src_ch0;
    logic [7:0] src_ch1;
    logic [7:0] src_ch2;
    logic [7:0] src_alpha;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_MUL,
    B_FIN
  } back_state_t;

  // floor(v / 255) for v up to 255*255: two adds and a shift
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = 17'(v) + 17'(v[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

>>> hw/rtl/clipped_alpha_blend_pixel_store.sv
// Top level of the clipped alpha-blend pixel store: front end, queue, back end.
// Depends on cabps_pkg, cabps_front, cabps_queue, cabps_back and the assert header.
//
// Each item is a blend-write or a read of one pixel of a FRAME_WIDTH x
// FRAME_HEIGHT store at address x + y*(clip width), and returns one result beat.
// The front end clips and addresses an item in the cycle it is accepted and
// parks it in a two-entry queue; the back end then pops it, reads the store,
// multiplies the channels, divides by 255 and writes back, and takes no new
// item until the last is done, since the read-modify-write sequence uses the
// single store port; write-back waits until the output register can take the
// result. A result waits in an output register while the next items are queued.
// After reset a clearing pass zeroes all FRAME_WIDTH*FRAME_HEIGHT words of the
// store, one word a cycle, during which in_tready stays low; configuration writes
// are taken throughout. Write the registers only while no item is in flight.
`include "clipped_alpha_blend_pixel_store_assert.svh"

module clipped_alpha_blend_pixel_store #(
  parameter int FRAME_WIDTH  = cabps_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = cabps_pkg::FRAME_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // pixel_x, pixel_y, src_ch0, src_ch1, src_ch2, src_alpha
  input  logic        in_tuser,  // func
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // out_ch0, out_ch1, out_ch2, out_alpha
  output logic        out_tuser  // in_range
);

  localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW     = ADDR_W + cabps_pkg::CMD_W;

  cabps_pkg::cfg_wr_t      cfg;
  cabps_pkg::q_status_t    q_status;
  cabps_pkg::back_status_t b_status;
  logic                    q_push, q_pop;
  logic [QW-1:0]           q_wdata, q_rdata;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  cabps_front #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .ADDR_W      (ADDR_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_status (q_status),
    .b_status (b_status),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  cabps_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .status   (q_status)
  );

  cabps_back #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .ADDR_W      (ADDR_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_data    (q_rdata),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .b_status  (b_status),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // No beat is taken and none is shown while the store is cleared
  `CABPS_ASSERT_IMP(a_no_accept_clear, clk, rst_n, b_status.clearing, !in_tready)
  `CABPS_ASSERT_IMP(a_no_result_clear, clk, rst_n, b_status.clearing, !out_tvalid)
  // Queue never overflows or underflows
  `CABPS_ASSERT_IMP(a_push_room, clk, rst_n, q_push, !q_status.full)
  `CABPS_ASSERT_IMP(a_pop_data, clk, rst_n, q_pop, !q_status.empty)
  // A popped item leaves the queue no fuller than before
  `CABPS_ASSERT_NXT(a_pop_frees, clk, rst_n, q_pop && !q_push, !q_status.full)

endmodule

>>> hw/rtl/cabps_front.sv
// Front end: holds the clip registers, accepts input beats, clips the
// coordinates and forms the store address. Depends on cabps_pkg.
module cabps_front #(
  parameter int FRAME_WIDTH  = cabps_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = cabps_pkg::FRAME_HEIGHT_DEF,
  parameter int ADDR_W       = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cabps_pkg::cfg_wr_t        cfg,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [55:0]               in_tdata,
  input  logic                      in_tuser,
  input  cabps_pkg::q_status_t      q_status,
  input  cabps_pkg::back_status_t   b_status,
  output logic                      q_push,
  output logic [ADDR_W+cabps_pkg::CMD_W-1:0] q_data
);

  localparam int W_LIM = (FRAME_WIDTH  > 511) ? 511 : FRAME_WIDTH;
  localparam int H_LIM = (FRAME_HEIGHT > 511) ? 511 : FRAME_HEIGHT;
  localparam logic [cabps_pkg::CLIP_W-1:0] W_SAT = cabps_pkg::CLIP_W'(W_LIM);
  localparam logic [cabps_pkg::CLIP_W-1:0] H_SAT = cabps_pkg::CLIP_W'(H_LIM);

  logic [cabps_pkg::CLIP_W-1:0] clip_cols_r, clip_height_r;
  logic [cabps_pkg::CLIP_W-1:0] w_eff, h_eff;
  logic [cabps_pkg::COORD_W-1:0] px, py;
  logic                          x_ok, y_ok, inr;
  logic [18:0]                   lin;
  logic [ADDR_W-1:0]             addr;
  cabps_pkg::cmd_t               cmd;

  // Clip registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_cols_r   <= cabps_pkg::CLIP_COLS_RST;
      clip_height_r <= cabps_pkg::CLIP_HEIGHT_RST;
    end else if (cfg.we) begin
      if (cfg.index == cabps_pkg::CFG_CLIP_COLS) begin
        clip_cols_r <= cfg.data[cabps_pkg::CLIP_W-1:0];
      end
      if (cfg.index == cabps_pkg::CFG_CLIP_HEIGHT) begin
        clip_height_r <= cfg.data[cabps_pkg::CLIP_W-1:0];
      end
    end
  end

  // Saturate the clip area to the frame
  assign w_eff = (clip_cols_r   > W_SAT) ? W_SAT : clip_cols_r;
  assign h_eff = (clip_height_r > H_SAT) ? H_SAT : clip_height_r;

  assign px = in_tdata[11:0];
  assign py = in_tdata[23:12];

  // Strict bounds on both axes; negative coordinates are out
  assign x_ok = !px[11] && (px[10:0] < 11'(w_eff));
  assign y_ok = !py[11] && (py[10:0] < 11'(h_eff));
  assign inr  = x_ok && y_ok;

  // Row-major address; both terms are below the saturated bounds when in range
  assign lin  = 19'(py[8:0]) * 19'(w_eff) + 19'(px[8:0]);
  assign addr = inr ? ADDR_W'(lin) : '0;

  always_comb begin
    cmd.func      = in_tuser;
    cmd.inr       = inr;
    cmd.src_ch0   = in_tdata[31:24];
    cmd.src_ch1   = in_tdata[39:32];
    cmd.src_ch2   = in_tdata[47:40];
    cmd.src_alpha = in_tdata[55:48];
  end

  // Accept while the queue has room and the store is not being cleared
  assign in_tready = !q_status.full && !b_status.clearing;
  assign q_push    = in_tvalid && in_tready;
  assign q_data    = {addr, cmd};

endmodule

>>> hw/rtl/cabps_queue.sv
// Two-entry queue between the front and back ends of the pixel store.
// Depends on cabps_pkg for the status struct.
module cabps_queue #(
  parameter int WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     pop_data,
  output cabps_pkg::q_status_t status
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  assign pop_data     = entry_r[rd_ptr_r];
  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);

endmodule

>>> hw/rtl/cabps_back.sv
// Back end: owns the frame store, its clearing pass, the blend arithmetic
// and the output register. Depends on cabps_pkg.
module cabps_back #(
  parameter int FRAME_WIDTH  = cabps_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = cabps_pkg::FRAME_HEIGHT_DEF,
  parameter int ADDR_W       = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cabps_pkg::cfg_wr_t      cfg,
  input  logic [ADDR_W+cabps_pkg::CMD_W-1:0] q_data,
  input  cabps_pkg::q_status_t    q_status,
  output logic                    q_pop,
  output cabps_pkg::back_status_t b_status,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [31:0]             out_tdata,
  output logic                    out_tuser
);

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [31:0]            store [DEPTH];
  cabps_pkg::back_state_t state_r, state_nxt;
  logic [ADDR_W-1:0]      clr_cnt_r;
  cabps_pkg::cmd_t        work_cmd_r;
  logic [ADDR_W-1:0]      work_addr_r;
  logic [31:0]            rd_data_r;
  logic [15:0]            sum0_r, sum1_r, sum2_r;
  logic [31:0]            fallback_r;
  logic                   out_valid_r;
  logic [31:0]            out_data_r;
  logic                   out_inr_r;

  logic                   out_load;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [31:0]            mem_wdata;
  logic [31:0]            blend_pix, res_pix;
  logic [7:0]             inv_a;

  // Fallback colour register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fallback_r <= cabps_pkg::FALLBACK_RST;
    end else if (cfg.we && cfg.index == cabps_pkg::CFG_FALLBACK) begin
      fallback_r <= cfg.data;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cabps_pkg::B_CLEAR: begin
        if (clr_cnt_r == LAST_ADDR) state_nxt = cabps_pkg::B_IDLE;
      end
      cabps_pkg::B_IDLE: begin
        if (!q_status.empty) state_nxt = cabps_pkg::B_READ;
      end
      cabps_pkg::B_READ: state_nxt = cabps_pkg::B_MUL;
      cabps_pkg::B_MUL:  state_nxt = cabps_pkg::B_FIN;
      cabps_pkg::B_FIN: begin
        if (!out_valid_r || out_tready) state_nxt = cabps_pkg::B_IDLE;
      end
      default: state_nxt = cabps_pkg::B_IDLE;
    endcase
  end

  // Blended pixel; an opaque source falls out of the same sum exactly
  assign blend_pix = {8'hFF, cabps_pkg::div255(sum2_r), cabps_pkg::div255(sum1_r),
                      cabps_pkg::div255(sum0_r)};

  always_comb begin
    if (work_cmd_r.func == cabps_pkg::FUNC_READ) begin
      res_pix = work_cmd_r.inr ? rd_data_r : fallback_r;
    end else begin
      res_pix = work_cmd_r.inr ? blend_pix : 32'd0;
    end
  end

  // Control outputs
  always_comb begin
    q_pop     = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = work_addr_r;
    mem_wdata = blend_pix;
    case (state_r)
      cabps_pkg::B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = 32'd0;
      end
      cabps_pkg::B_IDLE: q_pop = !q_status.empty;
      cabps_pkg::B_FIN: begin
        out_load = !out_valid_r || out_tready;
        mem_we   = out_load && work_cmd_r.inr && (work_cmd_r.func == cabps_pkg::FUNC_WRITE);
      end
      default: begin
      end
    endcase
  end

  // State and clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cabps_pkg::B_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == cabps_pkg::B_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
    end
  end

  // Frame store: one write port, registered read of the working address
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= store[work_addr_r];
  end

  // Take the next item from the queue
  always_ff @(posedge clk) begin
    if (q_pop) begin
      work_cmd_r  <= cabps_pkg::cmd_t'(q_data[cabps_pkg::CMD_W-1:0]);
      work_addr_r <= q_data[ADDR_W+cabps_pkg::CMD_W-1:cabps_pkg::CMD_W];
    end
  end

  // Weighted sums dst*(255-a) + src*a per channel
  assign inv_a = ~work_cmd_r.src_alpha;

  always_ff @(posedge clk) begin
    if (state_r == cabps_pkg::B_MUL) begin
      sum0_r <= {8'd0, rd_data_r[7:0]}   * {8'd0, inv_a}
              + {8'd0, work_cmd_r.src_ch0} * {8'd0, work_cmd_r.src_alpha};
      sum1_r <= {8'd0, rd_data_r[15:8]}  * {8'd0, inv_a}
              + {8'd0, work_cmd_r.src_ch1} * {8'd0, work_cmd_r.src_alpha};
      sum2_r <= {8'd0, rd_data_r[23:16]} * {8'd0, inv_a}
              + {8'd0, work_cmd_r.src_ch2} * {8'd0, work_cmd_r.src_alpha};
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_pix;
      out_inr_r  <= work_cmd_r.inr;
    end
  end

  assign b_status.clearing = (state_r == cabps_pkg::B_CLEAR);
  assign out_tvalid        = out_valid_r;
  assign out_tdata         = out_data_r;
  assign out_tuser         = out_inr_r;

endmodule
